/* hdl/utf8_to_ucs2_decoder_macros.svh */
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_macros.svh
// Assertion macros shared by the decoder checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UCS2_DECODER_MACROS_SVH
`define UTF8_TO_UCS2_DECODER_MACROS_SVH

// property checked out of reset only
`define U8D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also holds while reset is applied
`define U8D_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/u8dec_pkg.sv */
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types and constants of the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 16;
    localparam int COUNT_W = 16;
    localparam int STAGE_W = 2;

    // sequence stage codes
    localparam logic [STAGE_W-1:0] STAGE_IDLE   = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_LEAD   = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_SECOND = 2'd2;

    localparam logic [CODE_W-1:0]  REPLACEMENT_CHAR = 16'hFFFD;
    localparam logic [COUNT_W-1:0] LIMIT_RESET      = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;

    localparam logic [BYTE_W-1:0] MASK_TOP3  = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_TOP2  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_TWO   = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_MARK  = 8'h80;

    // decoder state carried between bytes
    typedef struct packed {
        logic [STAGE_W-1:0] stage;
        logic [BYTE_W-1:0]  lead;
        logic [BYTE_W-1:0]  second;
        logic [COUNT_W-1:0] count;
    } seq_state_t;

    // outcome of one byte
    typedef struct packed {
        logic               emit;
        logic               have;
        logic               last;
        logic [CODE_W-1:0]  code;
        logic [COUNT_W-1:0] count;
    } byte_result_t;

endpackage

/* hdl/utf8_to_ucs2_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// UTF-8 byte stream in, 16-bit code points and string counts out.
// ----------------------------------------------------------------------------
// result words are registered, valid the cycle after their byte is taken
// throughput: one byte per cycle unless a result word is stalled; the single
//   result register frees as it is taken, so bytes flow as results drain
// reset: rst_n clears the sequence state, the count and the output valid,
//   and sets out_limit to 65535
module utf8_to_ucs2_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,     // out_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // in_byte
    input  logic        s_tlast,       // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // code_point [15:0], char_count [31:16]
    output logic        m_tuser,       // code_valid
    output logic        m_tlast        // string_end
);

    logic [u8dec_pkg::COUNT_W-1:0] limit_reg;
    u8dec_pkg::seq_state_t         state_reg;
    u8dec_pkg::seq_state_t         state_next;
    u8dec_pkg::byte_result_t       res;
    logic                          in_fire;
    logic                          valid_reg;
    logic [31:0]                   data_reg;
    logic                          user_reg;
    logic                          last_reg;

    assign s_tready = !valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= u8dec_pkg::LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    u8dec_core u_core
    (
        .cur       (state_reg),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .out_limit (limit_reg),
        .nxt       (state_next),
        .res       (res)
    );

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (in_fire)
            state_reg <= state_next;
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_fire)
            valid_reg <= res.emit;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (in_fire && res.emit)
        begin
            data_reg <= {res.count, res.code};
            user_reg <= res.have;
            last_reg <= res.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

/* hdl/u8dec_core.sv */
// ----------------------------------------------------------------------------
// u8dec_core
// Per-byte decode: next sequence state and the result of one byte.
// ----------------------------------------------------------------------------
module u8dec_core
(
    input  u8dec_pkg::seq_state_t            cur,
    input  logic [u8dec_pkg::BYTE_W-1:0]     in_byte,
    input  logic                             in_last,
    input  logic [u8dec_pkg::COUNT_W-1:0]    out_limit,
    output u8dec_pkg::seq_state_t            nxt,
    output u8dec_pkg::byte_result_t          res
);

    logic                             have;
    logic [u8dec_pkg::CODE_W-1:0]     cp;
    logic                             b_cont;
    logic                             s_cont;
    logic [u8dec_pkg::COUNT_W-1:0]    count_inc;
    u8dec_pkg::seq_state_t            upd;

    assign b_cont = (in_byte & u8dec_pkg::MASK_TOP2) == u8dec_pkg::CONT_MARK;
    assign s_cont = (cur.second & u8dec_pkg::MASK_TOP2) == u8dec_pkg::CONT_MARK;

    // sequence assembly
    always_comb
    begin
        have = 1'b0;
        cp   = '0;
        upd  = cur;
        if (cur.count >= out_limit)
        begin
            upd.stage = u8dec_pkg::STAGE_IDLE;
        end
        else
        begin
            case (cur.stage)
                u8dec_pkg::STAGE_LEAD:
                begin
                    if ((cur.lead & u8dec_pkg::MASK_TOP3) == u8dec_pkg::LEAD_TWO)
                    begin
                        have      = 1'b1;
                        cp        = b_cont ? {5'd0, cur.lead[4:0], in_byte[5:0]}
                                           : u8dec_pkg::REPLACEMENT_CHAR;
                        upd.stage = u8dec_pkg::STAGE_IDLE;
                    end
                    else
                    begin
                        upd.second = in_byte;
                        upd.stage  = u8dec_pkg::STAGE_SECOND;
                    end
                end
                u8dec_pkg::STAGE_SECOND:
                begin
                    have = 1'b1;
                    if (((cur.lead & u8dec_pkg::MASK_TOP3) == u8dec_pkg::MASK_TOP3)
                        && s_cont && b_cont)
                        cp = {cur.lead[3:0], cur.second[5:0], in_byte[5:0]};
                    else
                        cp = u8dec_pkg::REPLACEMENT_CHAR;
                    upd.stage = u8dec_pkg::STAGE_IDLE;
                end
                default:
                begin
                    if (!in_byte[7])
                    begin
                        have      = 1'b1;
                        cp        = {8'd0, in_byte};
                        upd.stage = u8dec_pkg::STAGE_IDLE;
                    end
                    else
                    begin
                        upd.lead  = in_byte;
                        upd.stage = u8dec_pkg::STAGE_LEAD;
                    end
                end
            endcase
        end
    end

    // saturating count of produced code points
    assign count_inc = (have && cur.count != u8dec_pkg::COUNT_MAX)
                       ? cur.count + 16'd1 : cur.count;

    // end of string clears the state
    always_comb
    begin
        nxt       = upd;
        nxt.count = count_inc;
        if (in_last)
            nxt = '0;
    end

    assign res.emit  = have | in_last;
    assign res.have  = have;
    assign res.last  = in_last;
    assign res.code  = cp;
    assign res.count = count_inc;

endmodule

/* hdl/u8dec_checker.sv */
// ----------------------------------------------------------------------------
// u8dec_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_to_ucs2_decoder_macros.svh"

module u8dec_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast
);

    // stalled result word holds
    `U8D_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // a word without a character only closes a string
    `U8D_ASSERT(a_empty_is_end, m_tvalid && !m_tuser |-> m_tlast && m_tdata[15:0] == 16'd0, "empty word not closing")

    // a character word always counts itself
    `U8D_ASSERT(a_count_nonzero, m_tvalid && m_tuser |-> m_tdata[31:16] != 16'd0, "character with zero count")

    // no result word right out of reset
    `U8D_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid, "result valid after reset")

endmodule

bind utf8_to_ucs2_decoder u8dec_checker u_u8dec_checker (.*);
